FILE: sv/dpdos_pkg.sv
// ----------------------------------------------------------------------------
// dpdos_pkg
// Shared types and constants of the dual PID drive with oscillation stop.
// ----------------------------------------------------------------------------
package dpdos_pkg;

    // Move phase, also the status code of a result
    typedef enum logic [1:0] {
        PH_RUN  = 2'd0,
        PH_DONE = 2'd1,
        PH_OSC  = 2'd2,
        PH_IDLE = 2'd3
    } phase_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP_LIMIT    = 3'd5;

    localparam int CFG_W    = 16;
    localparam int TARGET_W = 16;
    localparam int POWER_W  = 7;
    localparam int GAIN_W   = 16;
    localparam int FLIP_W   = 4;
    localparam int DRIVE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_DW   = 40;
    localparam int LIM_W    = POWER_W + 16;

    // Reset values of the configuration registers
    localparam logic [TARGET_W-1:0] TARGET_RST = 16'd337;
    localparam logic [POWER_W-1:0]  POWER_RST  = 7'd45;
    localparam logic [GAIN_W-1:0]   GAIN_P_RST = 16'd25231;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST = 16'd164;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST = 16'd9830;
    localparam logic [FLIP_W-1:0]   FLIP_RST   = 4'd5;

    localparam logic [POWER_W-1:0]  POWER_CAP  = 7'd100;
    localparam logic [FLIP_W-1:0]   FLIP_SAT   = 4'd15;

endpackage

FILE: sv/dual_pid_drive_with_oscillation_stop_top.sv
// ----------------------------------------------------------------------------
// dual_pid_drive_with_oscillation_stop_top
// Two-wheel PID drive: per sample, error, saturating integral, derivative and
// sign-flip count per wheel; clamped, negated Q8.8 drive and move status.
// ----------------------------------------------------------------------------
//  channel   direction  signals                         contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser   encoder sample, start flag
//  m_        out        m_tvalid m_tready m_tdata          drives and status
//  cfg_      in         cfg_wr_en cfg_index cfg_wdata      register write
//
//  One item per cycle sustained while m_tready is high; m_tvalid rises when the
//  sample has passed the input register, state/term stage and product stage into
//  the result register.
//  Move state is updated in the state/term stage, so consecutive samples see
//  each other's updates with no bubble. No clearing pass after reset.
//  A stalled output holds its result; earlier stages keep filling until full.
// ----------------------------------------------------------------------------
module dual_pid_drive_with_oscillation_stop_top #(
    parameter int COUNT_BITS    = 16,
    parameter int INTEGRAL_BITS = 40
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [COUNT_BITS-1:0] left_count, [2*COUNT_BITS-1:COUNT_BITS] right_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]  s_tdata,
    // [0] start_req
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] left_drive, [31:16] right_drive, [33:32] status
    output logic [dpdos_pkg::OUT_DW-1:0]       m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [dpdos_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpdos_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int EW        = COUNT_BITS + 1;
    localparam int DW        = COUNT_BITS + 2;
    localparam int ICLIP_EXP = (COUNT_BITS + 19 < 46) ? COUNT_BITS + 19 : 46;
    localparam int IC_W      = ICLIP_EXP + 2;
    localparam int XW        = (INTEGRAL_BITS > IC_W) ? INTEGRAL_BITS : IC_W;
    localparam int ISW       = ((INTEGRAL_BITS > EW) ? INTEGRAL_BITS : EW) + 1;
    localparam int GW        = dpdos_pkg::GAIN_W + 1;
    localparam int PW        = GW + EW;
    localparam int IPW       = GW + IC_W;
    localparam int DPW       = GW + DW;
    localparam int SUMW      = IPW + 2;
    localparam int LIM_W     = dpdos_pkg::LIM_W;
    localparam int DRW       = dpdos_pkg::DRIVE_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [INTEGRAL_BITS-1:0] integ_add(
        input logic signed [INTEGRAL_BITS-1:0] acc,
        input logic signed [EW-1:0]            e
    );
        logic signed [ISW-1:0] s;
        logic signed [ISW-1:0] hi;
        logic signed [ISW-1:0] lo;
        s  = ISW'(acc) + ISW'(e);
        hi = ISW'({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
        lo = ~hi;
        if (s > hi) begin
            s = hi;
        end
        else if (s < lo) begin
            s = lo;
        end
        return s[INTEGRAL_BITS-1:0];
    endfunction

    // Limit the integral so the gain_i product stays narrow; beyond this
    // bound the clamped drive is already saturated.
    function automatic logic signed [IC_W-1:0] iclip(
        input logic signed [INTEGRAL_BITS-1:0] a
    );
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] pos;
        logic signed [XW-1:0] neg;
        x   = XW'(a);
        pos = XW'(1) <<< ICLIP_EXP;
        neg = -pos;
        if (x > pos) begin
            x = pos;
        end
        else if (x < neg) begin
            x = neg;
        end
        return x[IC_W-1:0];
    endfunction

    function automatic logic [dpdos_pkg::FLIP_W-1:0] flip_step(
        input logic [dpdos_pkg::FLIP_W-1:0] cnt,
        input logic signed [EW-1:0]         last,
        input logic signed [EW-1:0]         cur
    );
        logic flip;
        flip = (last > 0 && cur < 0) || (last < 0 && cur > 0);
        if (!flip) begin
            return '0;
        end
        return (cnt == dpdos_pkg::FLIP_SAT) ? cnt : cnt + 1'b1;
    endfunction

    // Sum, clamp to +-lim, round to Q8.8 (ties away from zero), negate
    function automatic logic signed [DRW-1:0] drive_of(
        input logic signed [PW-1:0]  p,
        input logic signed [IPW-1:0] i,
        input logic signed [DPW-1:0] d,
        input logic [LIM_W-1:0]      lim
    );
        logic signed [SUMW-1:0] s;
        logic signed [SUMW-1:0] l;
        logic [LIM_W-1:0]       mag;
        logic [LIM_W:0]         rnd;
        logic [DRW-1:0]         q;
        s = SUMW'(p) + SUMW'(i) + SUMW'(d);
        l = SUMW'({1'b0, lim});
        if (s > l) begin
            s = l;
        end
        else if (s < -l) begin
            s = -l;
        end
        mag = s[SUMW-1] ? LIM_W'(-s) : LIM_W'(s);
        rnd = (LIM_W+1)'(mag) + (LIM_W+1)'(128);
        q   = rnd[LIM_W:8];
        return s[SUMW-1] ? $signed(q) : -$signed(q);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dpdos_pkg::TARGET_W-1:0] target_counts_reg;
    logic [dpdos_pkg::POWER_W-1:0]  max_power_reg;
    logic [dpdos_pkg::GAIN_W-1:0]   gain_p_reg;
    logic [dpdos_pkg::GAIN_W-1:0]   gain_i_reg;
    logic [dpdos_pkg::GAIN_W-1:0]   gain_d_reg;
    logic [dpdos_pkg::FLIP_W-1:0]   flip_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_counts_reg <= dpdos_pkg::TARGET_RST;
            max_power_reg     <= dpdos_pkg::POWER_RST;
            gain_p_reg        <= dpdos_pkg::GAIN_P_RST;
            gain_i_reg        <= dpdos_pkg::GAIN_I_RST;
            gain_d_reg        <= dpdos_pkg::GAIN_D_RST;
            flip_limit_reg    <= dpdos_pkg::FLIP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                dpdos_pkg::CFG_TARGET_COUNTS:
                    target_counts_reg <= cfg_wdata[dpdos_pkg::TARGET_W-1:0];
                dpdos_pkg::CFG_MAX_POWER:
                    max_power_reg <= cfg_wdata[dpdos_pkg::POWER_W-1:0];
                dpdos_pkg::CFG_GAIN_P:
                    gain_p_reg <= cfg_wdata[dpdos_pkg::GAIN_W-1:0];
                dpdos_pkg::CFG_GAIN_I:
                    gain_i_reg <= cfg_wdata[dpdos_pkg::GAIN_W-1:0];
                dpdos_pkg::CFG_GAIN_D:
                    gain_d_reg <= cfg_wdata[dpdos_pkg::GAIN_W-1:0];
                dpdos_pkg::CFG_FLIP_LIMIT:
                    flip_limit_reg <= cfg_wdata[dpdos_pkg::FLIP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic adv12;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v4_reg;
    assign adv12    = v1_reg && en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                  p1_start_reg;
    logic [COUNT_BITS-1:0] p1_lc_reg;
    logic [COUNT_BITS-1:0] p1_rc_reg;

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            p1_start_reg <= s_tuser;
            p1_lc_reg    <= s_tdata[COUNT_BITS-1:0];
            p1_rc_reg    <= s_tdata[2*COUNT_BITS-1:COUNT_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: move state update and PID terms
    // ------------------------------------------------------------------
    dpdos_pkg::phase_t               phase_reg, phase_next, phase_cur;
    logic signed [EW-1:0]            last_l_reg, last_r_reg, last_l_next, last_r_next;
    logic signed [INTEGRAL_BITS-1:0] integ_l_reg, integ_r_reg, integ_l_next, integ_r_next;
    logic [dpdos_pkg::FLIP_W-1:0]    flips_l_reg, flips_r_reg, flips_l_next, flips_r_next;

    logic signed [EW-1:0]            last_l_cur, last_r_cur;
    logic signed [INTEGRAL_BITS-1:0] integ_l_cur, integ_r_cur;
    logic [dpdos_pkg::FLIP_W-1:0]    flips_l_cur, flips_r_cur;
    logic [COUNT_BITS-1:0]           tgt;
    logic signed [EW-1:0]            el, er;
    logic [COUNT_BITS:0]             count_sum;
    logic                            drive_on;

    assign tgt       = COUNT_BITS'(target_counts_reg);
    assign el        = $signed(EW'(tgt)) - $signed(EW'(p1_lc_reg));
    assign er        = $signed(EW'(tgt)) - $signed(EW'(p1_rc_reg));
    assign count_sum = (COUNT_BITS+1)'(p1_lc_reg) + (COUNT_BITS+1)'(p1_rc_reg);

    // Start request clears the move before this sample is used
    assign phase_cur   = p1_start_reg ? dpdos_pkg::PH_RUN : phase_reg;
    assign last_l_cur  = p1_start_reg ? '0 : last_l_reg;
    assign last_r_cur  = p1_start_reg ? '0 : last_r_reg;
    assign integ_l_cur = p1_start_reg ? '0 : integ_l_reg;
    assign integ_r_cur = p1_start_reg ? '0 : integ_r_reg;
    assign flips_l_cur = p1_start_reg ? '0 : flips_l_reg;
    assign flips_r_cur = p1_start_reg ? '0 : flips_r_reg;

    // Next state of the move
    always_comb
    begin
        phase_next   = phase_cur;
        last_l_next  = last_l_cur;
        last_r_next  = last_r_cur;
        integ_l_next = integ_l_cur;
        integ_r_next = integ_r_cur;
        flips_l_next = flips_l_cur;
        flips_r_next = flips_r_cur;
        unique case (phase_cur)
            dpdos_pkg::PH_RUN:
            begin
                flips_l_next = flip_step(flips_l_cur, last_l_cur, el);
                flips_r_next = flip_step(flips_r_cur, last_r_cur, er);
                if (flips_l_next >= flip_limit_reg || flips_r_next >= flip_limit_reg)
                begin
                    phase_next = dpdos_pkg::PH_OSC;
                end
                else if (count_sum >= {tgt, 1'b0})
                begin
                    phase_next = dpdos_pkg::PH_DONE;
                end
                else
                begin
                    integ_l_next = integ_add(integ_l_cur, el);
                    integ_r_next = integ_add(integ_r_cur, er);
                    last_l_next  = el;
                    last_r_next  = er;
                end
            end
            dpdos_pkg::PH_DONE,
            dpdos_pkg::PH_OSC,
            dpdos_pkg::PH_IDLE:
                ;
            default:
                ;
        endcase
    end

    // Drive only while the move keeps running
    always_comb
    begin
        drive_on = (phase_cur == dpdos_pkg::PH_RUN) && (phase_next == dpdos_pkg::PH_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dpdos_pkg::PH_IDLE;
            last_l_reg  <= '0;
            last_r_reg  <= '0;
            integ_l_reg <= '0;
            integ_r_reg <= '0;
            flips_l_reg <= '0;
            flips_r_reg <= '0;
        end
        else if (adv12)
        begin
            phase_reg   <= phase_next;
            last_l_reg  <= last_l_next;
            last_r_reg  <= last_r_next;
            integ_l_reg <= integ_l_next;
            integ_r_reg <= integ_r_next;
            flips_l_reg <= flips_l_next;
            flips_r_reg <= flips_r_next;
        end
    end

    logic signed [EW-1:0]   p2_el_reg, p2_er_reg;
    logic signed [DW-1:0]   p2_dl_reg, p2_dr_reg;
    logic signed [IC_W-1:0] p2_icl_reg, p2_icr_reg;
    logic                   p2_on_reg;
    dpdos_pkg::phase_t      p2_status_reg;

    always_ff @(posedge clk)
    begin
        if (adv12)
        begin
            p2_el_reg     <= el;
            p2_er_reg     <= er;
            p2_dl_reg     <= $signed(DW'(el)) - $signed(DW'(last_l_cur));
            p2_dr_reg     <= $signed(DW'(er)) - $signed(DW'(last_r_cur));
            p2_icl_reg    <= iclip(integ_l_next);
            p2_icr_reg    <= iclip(integ_r_next);
            p2_on_reg     <= drive_on;
            p2_status_reg <= phase_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gain products
    // ------------------------------------------------------------------
    logic signed [GW-1:0]  gp_s, gi_s, gd_s;
    logic signed [PW-1:0]  p3_pl_reg, p3_pr_reg;
    logic signed [IPW-1:0] p3_il_reg, p3_ir_reg;
    logic signed [DPW-1:0] p3_dl_reg, p3_dr_reg;
    logic                  p3_on_reg;
    dpdos_pkg::phase_t     p3_status_reg;

    assign gp_s = $signed({1'b0, gain_p_reg});
    assign gi_s = $signed({1'b0, gain_i_reg});
    assign gd_s = $signed({1'b0, gain_d_reg});

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            p3_pl_reg     <= gp_s * p2_el_reg;
            p3_pr_reg     <= gp_s * p2_er_reg;
            p3_il_reg     <= gi_s * p2_icl_reg;
            p3_ir_reg     <= gi_s * p2_icr_reg;
            p3_dl_reg     <= gd_s * p2_dl_reg;
            p3_dr_reg     <= gd_s * p2_dr_reg;
            p3_on_reg     <= p2_on_reg;
            p3_status_reg <= p2_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, clamp, round, result register
    // ------------------------------------------------------------------
    logic [dpdos_pkg::POWER_W-1:0] mp;
    logic [LIM_W-1:0]              lim;
    logic signed [DRW-1:0]         ld, rd;
    logic signed [DRW-1:0]         out_ld_reg, out_rd_reg;
    dpdos_pkg::phase_t             out_status_reg;

    assign mp  = (max_power_reg > dpdos_pkg::POWER_CAP) ? dpdos_pkg::POWER_CAP : max_power_reg;
    assign lim = {mp, 16'd0};
    assign ld  = p3_on_reg ? drive_of(p3_pl_reg, p3_il_reg, p3_dl_reg, lim) : '0;
    assign rd  = p3_on_reg ? drive_of(p3_pr_reg, p3_ir_reg, p3_dr_reg, lim) : '0;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            out_ld_reg     <= ld;
            out_rd_reg     <= rd;
            out_status_reg <= p3_status_reg;
        end
    end

    assign m_tdata = {(dpdos_pkg::OUT_DW - 2*DRW - dpdos_pkg::STATUS_W)'(0),
                      out_status_reg, out_rd_reg, out_ld_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stopped_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg != dpdos_pkg::PH_RUN)
            |-> (out_ld_reg == '0 && out_rd_reg == '0))
        else $error("nonzero drive on a stopped move");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_ld_reg <= 16'sd25600 && out_ld_reg >= -16'sd25600 &&
                      out_rd_reg <= 16'sd25600 && out_rd_reg >= -16'sd25600))
        else $error("drive beyond full power");

    a_phase_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != dpdos_pkg::PH_RUN && !(adv12 && p1_start_reg))
            |=> (phase_reg == $past(phase_reg)))
        else $error("stopped move left its phase without a start");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_tready)
        else $error("empty pipeline refuses input");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !adv12 |=> ($stable(phase_reg) && $stable(integ_l_reg) && $stable(integ_r_reg)))
        else $error("move state changed without an item");

endmodule
